### rtl/core/sinc_function_unit_defines.svh
// Assertion macros shared by the sinc function unit RTL.
`ifndef SINC_FUNCTION_UNIT_DEFINES_SVH
`define SINC_FUNCTION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SFU_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SFU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sfu_pkg.sv
// Constants and types shared by the sinc function unit modules.
`timescale 1ns / 1ps
package sfu_pkg;
	localparam logic [55:0] TWO_PI_Q48  = 56'd1768559438007110;
	localparam logic [55:0] PI_Q48      = 56'd884279719003555;
	localparam logic [55:0] HALF_PI_Q48 = 56'd442139859501777;
	localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

	localparam int SER_STEPS = 8;
	localparam logic [8:0] SER_DIV [SER_STEPS] = '{
		9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
	};
	localparam logic [29:0] SER_REC [SER_STEPS] = '{
		30'(64'h1_0000_0000 / 64'd272), 30'(64'h1_0000_0000 / 64'd210),
		30'(64'h1_0000_0000 / 64'd156), 30'(64'h1_0000_0000 / 64'd110),
		30'(64'h1_0000_0000 / 64'd72),  30'(64'h1_0000_0000 / 64'd42),
		30'(64'h1_0000_0000 / 64'd20),  30'(64'h1_0000_0000 / 64'd6)
	};

	localparam int DIV_BITS = 18;

	typedef struct packed {
		logic [23:0] a;
		logic        zero;
		logic        series_only;
		logic        neg;
		logic [30:0] t;
		logic [16:0] sv;
		logic        last;
	} sfu_pay_t;
endpackage

### rtl/core/sfu_series.sv
// Pipelined eight-term sin(x)/x series in Q30, three stages per term.
`timescale 1ns / 1ps
`include "sinc_function_unit_defines.svh"
module sfu_series (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ce,
	input  logic             in_vld,
	input  logic [31:0]      in_u,
	input  sfu_pkg::sfu_pay_t in_pay,
	output logic             out_vld,
	output logic [30:0]      out_h,
	output sfu_pkg::sfu_pay_t out_pay
);
	import sfu_pkg::*;

	logic        vld_sa [SER_STEPS];
	logic        vld_sb [SER_STEPS];
	logic        vld_sc [SER_STEPS];
	logic [31:0] u_sa   [SER_STEPS];
	logic [31:0] u_sb   [SER_STEPS];
	logic [31:0] u_sc   [SER_STEPS];
	logic [31:0] p_sa   [SER_STEPS];
	logic [31:0] p_sb   [SER_STEPS];
	logic [29:0] qe_sb  [SER_STEPS];
	logic [30:0] h_sc   [SER_STEPS];
	sfu_pay_t    pay_sa [SER_STEPS];
	sfu_pay_t    pay_sb [SER_STEPS];
	sfu_pay_t    pay_sc [SER_STEPS];

	for (genvar i = 0; i < SER_STEPS; i++) begin : g_step
		logic        vin;
		logic [31:0] uin;
		logic [30:0] hin;
		sfu_pay_t    pin;
		logic [62:0] prod_a;
		logic [61:0] prod_b;
		logic [39:0] back;
		logic [31:0] rem;
		logic [29:0] qc;

		if (i == 0) begin : g_first
			assign vin = in_vld;
			assign uin = in_u;
			assign hin = ONE_Q30;
			assign pin = in_pay;
		end else begin : g_next
			assign vin = vld_sc[i-1];
			assign uin = u_sc[i-1];
			assign hin = h_sc[i-1];
			assign pin = pay_sc[i-1];
		end

		assign prod_a = 63'(uin) * 63'(hin);
		assign prod_b = 62'(p_sa[i]) * 62'(SER_REC[i]);
		assign back   = 40'(qe_sb[i]) * 40'(SER_DIV[i]);
		assign rem    = p_sb[i] - back[31:0];
		assign qc     = qe_sb[i] + 30'(rem >= 32'(SER_DIV[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sa[i] <= 1'b0;
				vld_sb[i] <= 1'b0;
				vld_sc[i] <= 1'b0;
			end else if (ce) begin
				vld_sa[i] <= vin;
				vld_sb[i] <= vld_sa[i];
				vld_sc[i] <= vld_sb[i];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				p_sa[i]   <= prod_a[61:30];
				u_sa[i]   <= uin;
				pay_sa[i] <= pin;
				p_sb[i]   <= p_sa[i];
				qe_sb[i]  <= prod_b[61:32];
				u_sb[i]   <= u_sa[i];
				pay_sb[i] <= pay_sa[i];
				h_sc[i]   <= ONE_Q30 - {1'b0, qc};
				u_sc[i]   <= u_sb[i];
				pay_sc[i] <= pay_sb[i];
			end
		end
	end

	assign out_vld = vld_sc[SER_STEPS-1];
	assign out_h   = h_sc[SER_STEPS-1];
	assign out_pay = pay_sc[SER_STEPS-1];

	`SFU_ASSERT(a_h_range, out_vld, (out_h != '0) && (out_h <= ONE_Q30), "series term out of range")
	`SFU_ASSERT(a_rem_small, vld_sb[0], (p_sb[0] - g_step[0].back[31:0]) < 32'd544,
		"reciprocal estimate off by more than one")
endmodule

### rtl/core/sfu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`include "sinc_function_unit_defines.svh"
module sfu_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ce,
	input  logic              in_vld,
	input  logic [33:0]       in_num,
	input  sfu_pkg::sfu_pay_t in_pay,
	output logic              out_vld,
	output logic [17:0]       out_quo,
	output sfu_pkg::sfu_pay_t out_pay
);
	import sfu_pkg::*;

	logic                vld_sd [DIV_BITS];
	logic [33:0]         rem_sd [DIV_BITS];
	logic [DIV_BITS-1:0] q_sd   [DIV_BITS];
	sfu_pay_t            pay_sd [DIV_BITS];

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_bit
		localparam int K = DIV_BITS - 1 - j;
		logic                vin;
		logic [33:0]         rin;
		logic [DIV_BITS-1:0] qin;
		sfu_pay_t            pin;
		logic [41:0]         dsh;
		logic [41:0]         rext;
		logic                ge;

		if (j == 0) begin : g_first
			assign vin = in_vld;
			assign rin = in_num;
			assign qin = '0;
			assign pin = in_pay;
		end else begin : g_next
			assign vin = vld_sd[j-1];
			assign rin = rem_sd[j-1];
			assign qin = q_sd[j-1];
			assign pin = pay_sd[j-1];
		end

		assign dsh  = 42'(pin.a) << K;
		assign rext = 42'(rin);
		assign ge   = rext >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[j] <= 1'b0;
			end else if (ce) begin
				vld_sd[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_sd[j] <= ge ? 34'(rext - dsh) : rin;
				q_sd[j]   <= qin | (DIV_BITS'(ge) << K);
				pay_sd[j] <= pin;
			end
		end
	end

	assign out_vld = vld_sd[DIV_BITS-1];
	assign out_quo = q_sd[DIV_BITS-1];
	assign out_pay = pay_sd[DIV_BITS-1];

	`SFU_ASSERT(a_rem_below_div, out_vld && !out_pay.series_only,
		rem_sd[DIV_BITS-1] < 34'(out_pay.a), "divider remainder not below divisor")
endmodule

### rtl/core/sinc_function_unit.sv
// Top level of the streaming sin(x)/x unit.
`timescale 1ns / 1ps
`include "sinc_function_unit_defines.svh"
// One beat in on the slave side gives one beat out on the master side, in order.
// s_axis_tdata carries x, signed Q8.16 radians; s_axis_tlast marks a buffer end.
// m_axis_tdata carries sin(x)/x, signed Q2.16 with 65536 = 1.0, rounded to nearest;
// m_axis_tlast repeats the input flag. An input of exactly zero yields 65536.
// Small arguments use the series directly; larger ones are reduced modulo 2*pi,
// go through the same series and are divided by |x| in a one-bit-per-stage divider.
// The datapath is 54 register stages deep from an input beat to its output beat.
// Throughput is one beat per cycle while m_axis_tready does not stall the output;
// every stage is a register and the datapath is fully pipelined, the longest
// part being the 24 stages of the series.
// The pipeline advances as a whole: when the output beat is held and m_axis_tready
// is low, every stage holds and s_axis_tready drops in the same cycle.
// Reset clears all valid bits, so no beat is offered until new input arrives.
module sinc_function_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] x
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [17:0] value, [23:18] zero
	output logic        m_axis_tlast
);
	import sfu_pkg::*;

	localparam logic [30:0] HALF_PI_T = HALF_PI_Q48[48:18];

	logic ce;
	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	logic [23:0] x_abs;
	assign x_abs = s_axis_tdata[23] ? (~s_axis_tdata + 24'd1) : s_axis_tdata;

	logic     vld_s1;
	sfu_pay_t pay_s1;
	sfu_pay_t pay_n1;

	always_comb begin
		pay_n1             = '0;
		pay_n1.a           = x_abs;
		pay_n1.zero        = (x_abs == '0);
		pay_n1.series_only = (x_abs[23:16] == '0);
		pay_n1.last        = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			pay_s1 <= pay_n1;
		end
	end

	// Reduction of |x| * 2^32 modulo 2*pi, one power-of-two multiple of 2*pi (16, 8, 4, 2, then 1) per stage.
	logic        vld_rd_s [5];
	logic [55:0] rem_rd_s [5];
	sfu_pay_t    pay_rd_s [5];

	for (genvar j = 0; j < 5; j++) begin : g_red
		localparam logic [55:0] STEP = TWO_PI_Q48 << (4 - j);
		logic        vin;
		logic [55:0] rin;
		sfu_pay_t    pin;

		if (j == 0) begin : g_first
			assign vin = vld_s1;
			assign rin = {pay_s1.a, 32'd0};
			assign pin = pay_s1;
		end else begin : g_next
			assign vin = vld_rd_s[j-1];
			assign rin = rem_rd_s[j-1];
			assign pin = pay_rd_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rd_s[j] <= 1'b0;
			end else if (ce) begin
				vld_rd_s[j] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_rd_s[j] <= (rin >= STEP) ? (rin - STEP) : rin;
				pay_rd_s[j] <= pin;
			end
		end
	end

	logic        vld_s7, vld_s8, vld_s9;
	logic [49:0] r_s7;
	logic [30:0] t_s8;
	logic [29:0] us_s8;
	logic [31:0] u_s9;
	sfu_pay_t    pay_s7, pay_s8, pay_s9;
	sfu_pay_t    pay_n7, pay_n8;

	logic        ge_pi;
	logic [55:0] r_half;
	logic [49:0] r_fold;
	logic [31:0] sq_small;
	logic [61:0] sq_large;

	assign ge_pi    = rem_rd_s[4] >= PI_Q48;
	assign r_half   = ge_pi ? (rem_rd_s[4] - PI_Q48) : rem_rd_s[4];
	assign r_fold   = (56'(r_s7) > HALF_PI_Q48) ? (PI_Q48[49:0] - r_s7) : r_s7;
	assign sq_small = 32'(pay_s7.a[15:0]) * 32'(pay_s7.a[15:0]);
	assign sq_large = 62'(t_s8) * 62'(t_s8);

	always_comb begin
		pay_n7     = pay_rd_s[4];
		pay_n7.neg = ge_pi;
	end

	always_comb begin
		pay_n8   = pay_s7;
		pay_n8.t = r_fold[48:18];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (ce) begin
			vld_s7 <= vld_rd_s[4];
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			r_s7   <= r_half[49:0];
			pay_s7 <= pay_n7;
			t_s8   <= r_fold[48:18];
			us_s8  <= sq_small[31:2];
			pay_s8 <= pay_n8;
			u_s9   <= pay_s8.series_only ? {2'b00, us_s8} : sq_large[61:30];
			pay_s9 <= pay_s8;
		end
	end

	logic        vld_sr;
	logic [30:0] h_sr;
	sfu_pay_t    pay_sr;

	sfu_series u_series (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_s9),
		.in_u    (u_s9),
		.in_pay  (pay_s9),
		.out_vld (vld_sr),
		.out_h   (h_sr),
		.out_pay (pay_sr)
	);

	logic        vld_s34, vld_s35;
	logic [31:0] s_s34;
	logic [33:0] n_s35;
	sfu_pay_t    pay_s34, pay_s35;
	sfu_pay_t    pay_n34;
	logic [61:0] ts_prod;
	logic [30:0] h_rnd;

	assign ts_prod = 62'(pay_sr.t) * 62'(h_sr);
	assign h_rnd   = h_sr + 31'd8192;

	always_comb begin
		pay_n34    = pay_sr;
		pay_n34.sv = h_rnd[30:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s34 <= 1'b0;
			vld_s35 <= 1'b0;
		end else if (ce) begin
			vld_s34 <= vld_sr;
			vld_s35 <= vld_s34;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			s_s34   <= ts_prod[61:30];
			pay_s34 <= pay_n34;
			n_s35   <= {s_s34, 2'b00} + 34'(pay_s34.a[23:1]);
			pay_s35 <= pay_s34;
		end
	end

	logic        vld_dv;
	logic [17:0] q_dv;
	sfu_pay_t    pay_dv;

	sfu_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.in_vld  (vld_s35),
		.in_num  (n_s35),
		.in_pay  (pay_s35),
		.out_vld (vld_dv),
		.out_quo (q_dv),
		.out_pay (pay_dv)
	);

	logic [18:0] res;

	always_comb begin
		if (pay_dv.zero) begin
			res = 19'd65536;
		end else if (pay_dv.series_only) begin
			res = {2'b00, pay_dv.sv};
		end else if (!pay_dv.neg) begin
			res = (q_dv > 18'd131071) ? 19'd131071 : {1'b0, q_dv};
		end else begin
			res = (q_dv > 18'd131072) ? 19'h60000 : (19'd0 - {1'b0, q_dv});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			m_axis_tvalid <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_axis_tdata <= {6'd0, res[17:0]};
			m_axis_tlast <= pay_dv.last;
		end
	end

	`SFU_ASSERT(a_fold_range, vld_s8, t_s8 <= HALF_PI_T, "reduced angle beyond pi/2")
	`SFU_ASSERT(a_quo_bound, vld_dv && !pay_dv.series_only, q_dv <= 18'd65536,
		"large argument quotient above one")
	`SFU_ASSERT_NXT(a_stall_hold, !ce && vld_s9, vld_s9 && $stable(u_s9),
		"series input moved during stall")
endmodule

### verif/tb_sinc_function_unit.sv
// Self-checking testbench for the streaming sin(x)/x unit.
`timescale 1ns / 1ps
module tb_sinc_function_unit;
	localparam int XW = 24;
	localparam int VW = 18;
	localparam int LATENCY = 54;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [55:0] TWO_PI = 56'd1768559438007110;
	localparam logic [55:0] PI = 56'd884279719003555;
	localparam logic [55:0] HALF_PI = 56'd442139859501777;
	localparam logic [63:0] ONE = 64'd1 << 30;

	typedef struct packed {
		logic [XW-1:0] x;
		logic          last;
	} sample_t;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          last;
	} sinc_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;

	sample_t pending_samples[$];
	sinc_t   expected_sinc[$];
	int      error_count;
	longint  cycle_count;
	int      send_gap;
	int      recv_gap;
	int      hold_off;
	bit      drain_request;

	sinc_function_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] taylor_sinc(logic [63:0] u);
		logic [63:0] h;
		logic [63:0] divs [8];
		divs = '{64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
		h = ONE;
		for (int i = 0; i < 8; i++)
			h = ONE - (((u * h) >> 30) / divs[i]);
		return h;
	endfunction

	function automatic sinc_t predict_sinc(sample_t s);
		logic [63:0] a, r, t, sv, m, h;
		logic [XW-1:0] mag;
		logic [127:0] wide;
		logic neg;
		longint res;
		sinc_t o;
		mag = s.x[XW-1] ? (~s.x + 1'b1) : s.x;
		a = 64'(mag);
		neg = 1'b0;
		if (a == 0) begin
			res = 65536;
		end else if (a < 64'd65536) begin
			h = taylor_sinc((a * a) >> 2);
			res = longint'((h + 64'd8192) >> 14);
		end else begin
			wide = {64'd0, a} << 32;
			r = 64'(wide % {72'd0, TWO_PI});
			if (r >= PI) begin
				r = r - PI;
				neg = 1'b1;
			end
			if (r > HALF_PI)
				r = PI - r;
			t = r >> 18;
			sv = (t * taylor_sinc((t * t) >> 30)) >> 30;
			m = (4 * sv + (a >> 1)) / a;
			res = neg ? -longint'(m) : longint'(m);
		end
		if (res > 131071)
			res = 131071;
		if (res < -131072)
			res = -131072;
		o.value = VW'(res);
		o.last = s.last;
		return o;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [XW-1:0] random_x();
		case ($urandom_range(0, 5))
			0: return XW'($urandom_range(0, 65535));
			1: return -XW'($urandom_range(1, 65535));
			2: return XW'($urandom_range(0, 255));
			3: return -XW'($urandom_range(0, 255));
			default: return XW'($urandom);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t s;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid)
				expected_sinc.push_back(predict_sinc({s_axis_tdata, s_axis_tlast}));
			if (send_gap > 0 || pending_samples.size() == 0 ||
					(drain_request && expected_sinc.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else begin
				s = pending_samples.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= s.x;
				s_axis_tlast <= s.last;
				send_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		sinc_t exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_sinc.size() == 0) begin
					$error("unexpected beat: value %0d", m_axis_tdata[VW-1:0]);
					error_count++;
				end else begin
					exp_r = expected_sinc.pop_front();
					if (m_axis_tdata[VW-1:0] !== exp_r.value) begin
						$error("value: expected %0d actual %0d", $signed(exp_r.value),
							$signed(m_axis_tdata[VW-1:0]));
						error_count++;
					end
					if (m_axis_tdata[23:VW] !== '0) begin
						$error("pad: expected 0 actual %0h", m_axis_tdata[23:VW]);
						error_count++;
					end
					if (m_axis_tlast !== exp_r.last) begin
						$error("last: expected %0b actual %0b", exp_r.last, m_axis_tlast);
						error_count++;
					end
				end
			end
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				m_axis_tready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				recv_gap <= pick_gap();
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_off <= 300;
		else if (hold_off > 0)
			hold_off <= hold_off - 1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [XW-1:0] directed [$];
		drain_request = 0;
		arst_n = 1'b0;
		directed = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h00FFFF, 24'hFF0001,
			24'h010000, 24'hFF0000, 24'h7FFFFF, 24'h800000, 24'h800001,
			24'h032440, 24'hFCDBC0, 24'h019220, 24'h064880, 24'h555555,
			24'hAAAAAA, 24'h000100, 24'h00C000};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			pending_samples.push_back({directed[i], 1'(i % 2)});
		for (int i = 0; i < 400; i++)
			pending_samples.push_back({random_x(), 1'($urandom_range(0, 1))});
		while (pending_samples.size() != 0)
			@(posedge clk);
		drain_request = 1;
		while (expected_sinc.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		@(posedge clk);
		drain_request = 0;
		for (int i = 0; i < 830; i++)
			pending_samples.push_back({random_x(), 1'($urandom_range(0, 7) == 0)});
		while (pending_samples.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_sinc.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (error_count == 0 && expected_sinc.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
